// ===== sv/rfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_pkg: shared types and constants of the reads-from resolver
// Field widths, action and status codes, the classification flags that the
// front part hands to the back part, and default table dimensions.
// ----------------------------------------------------------------------------
package rfr_pkg;

    localparam int RFR_ADDR_COUNT  = 64;
    localparam int RFR_VALUE_COUNT = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam int ADDR_W   = 6;
    localparam int VALUE_W  = 8;
    localparam int ID_W     = 12;
    localparam int STATUS_W = 3;

    localparam logic ACT_RECORD  = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_RECORDED  = 3'd0,
        ST_AMBIGUOUS = 3'd1,
        ST_RESOLVED  = 3'd2,
        ST_INITIAL   = 3'd3,
        ST_NO_STORE  = 3'd4
    } status_t;

    typedef struct packed {
        logic action;
        logic in_range;
        logic zero_value;
    } cls_t;

endpackage

// ===== sv/reads_from_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reads_from_resolver: reads-from resolver for a memory trace
// Records the writer of each (address, value) key and resolves reads to
// their source store, the initial value, or a missing store.
//
//   Channel   Signals                                     Direction
//   input     in_valid, in_stall, action, address,        in
//             data_value, instr_id
//   output    out_valid, out_stall, status, source_id     out
//
// In the back part, B_IDLE pops a beat and starts the registered table read
// for an in-range key; B_EVAL then evaluates it, updates the table and loads
// the result register, waiting while out_stall holds the last result. After
// reset, a clearing pass zeroes all ADDR_COUNT * VALUE_COUNT table entries
// with in_stall held high. A two-entry queue lets the input side keep
// accepting while a result waits behind out_stall.
// ----------------------------------------------------------------------------
module reads_from_resolver
    import rfr_pkg::*;
#(
    parameter int ADDR_COUNT  = RFR_ADDR_COUNT,
    parameter int VALUE_COUNT = RFR_VALUE_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [ADDR_W-1:0]   address,
    input  logic [VALUE_W-1:0]  data_value,
    input  logic [ID_W-1:0]     instr_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     source_id
);

    localparam int KEY_W = $clog2(ADDR_COUNT * VALUE_COUNT);
    localparam int Q_W   = $bits(cls_t) + KEY_W + ID_W;

    logic             push;
    cls_t             push_cls;
    logic [KEY_W-1:0] push_key;
    logic [ID_W-1:0]  push_id;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    logic [Q_W-1:0]   q_head;
    cls_t             q_cls;
    logic [KEY_W-1:0] q_key;
    logic [ID_W-1:0]  q_id;
    logic             clearing;

    assign {q_cls, q_key, q_id} = q_head;

    rfr_front #(
        .ADDR_COUNT  (ADDR_COUNT),
        .VALUE_COUNT (VALUE_COUNT),
        .KEY_W       (KEY_W)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .address    (address),
        .data_value (data_value),
        .instr_id   (instr_id),
        .clearing   (clearing),
        .q_full     (q_full),
        .push       (push),
        .push_cls   (push_cls),
        .push_key   (push_key),
        .push_id    (push_id)
    );

    rfr_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cls, push_key, push_id}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rfr_back #(
        .ADDR_COUNT  (ADDR_COUNT),
        .VALUE_COUNT (VALUE_COUNT),
        .KEY_W       (KEY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cls       (q_cls),
        .q_key       (q_key),
        .q_id        (q_id),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .source_id   (source_id)
    );

endmodule

// ===== sv/rfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfr_ram #(
    parameter int DATA_W = 13,
    parameter int DEPTH  = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/rfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_front: input acceptance and classification
// Forms the table key, checks its range and flags a zero value, then pushes
// the classified beat into the queue toward the back part.
// ----------------------------------------------------------------------------
module rfr_front
    import rfr_pkg::*;
#(
    parameter int ADDR_COUNT  = RFR_ADDR_COUNT,
    parameter int VALUE_COUNT = RFR_VALUE_COUNT,
    parameter int KEY_W       = $clog2(ADDR_COUNT * VALUE_COUNT)
) (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [ADDR_W-1:0]  address,
    input  logic [VALUE_W-1:0] data_value,
    input  logic [ID_W-1:0]    instr_id,
    input  logic               clearing,
    input  logic               q_full,
    output logic               push,
    output cls_t               push_cls,
    output logic [KEY_W-1:0]   push_key,
    output logic [ID_W-1:0]    push_id
);

    logic in_range;

    always_comb
    begin
        in_range = (32'(address) < 32'(ADDR_COUNT)) && (32'(data_value) < 32'(VALUE_COUNT));
        in_stall = clearing | q_full;
        push     = in_valid & ~in_stall;

        push_cls.action     = action;
        push_cls.in_range   = in_range;
        push_cls.zero_value = (data_value == '0);
        push_key = KEY_W'(32'(data_value) * 32'(ADDR_COUNT) + 32'(address));
        push_id  = instr_id;
    end

endmodule

// ===== sv/rfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_queue: short queue between the front and back parts
// A small register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rfr_queue
    import rfr_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        full      = (count_reg == CNT_W'(DEPTH));
        not_empty = (count_reg != '0);
        head      = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/rfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_back: table lookup, update and result register
// Clears the key table after reset, then reads the table for each queued
// in-range beat, records new writers, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rfr_back
    import rfr_pkg::*;
#(
    parameter int ADDR_COUNT  = RFR_ADDR_COUNT,
    parameter int VALUE_COUNT = RFR_VALUE_COUNT,
    parameter int KEY_W       = $clog2(ADDR_COUNT * VALUE_COUNT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  cls_t                q_cls,
    input  logic [KEY_W-1:0]    q_key,
    input  logic [ID_W-1:0]     q_id,
    output logic                q_pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     source_id
);

    localparam int DEPTH  = ADDR_COUNT * VALUE_COUNT;
    localparam int WORD_W = ID_W + 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EVAL = 2'b10
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                clearing_reg;
    logic                clearing_next;
    logic [KEY_W-1:0]    clr_idx_reg;
    logic [KEY_W-1:0]    clr_idx_next;
    cls_t                cls_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ID_W-1:0]     id_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [ID_W-1:0]     source_id_reg;
    logic [ID_W-1:0]     source_id_next;

    logic                ram_we;
    logic [KEY_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_W-1:0]   ram_rdata;
    logic                upd_we;
    logic                hit;
    logic                out_free;
    logic                fire;

    rfr_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_key),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clearing_next  = clearing_reg;
        clr_idx_next   = clr_idx_reg;
        status_next    = status_reg;
        source_id_next = source_id_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        upd_we         = 1'b0;
        fire           = 1'b0;

        hit      = cls_reg.in_range & ram_rdata[ID_W];
        out_free = ~out_valid_reg | ~out_stall;

        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == KEY_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty && !clearing_reg)
                begin
                    q_pop      = 1'b1;
                    ram_re     = q_cls.in_range;
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                if (out_free)
                begin
                    fire           = 1'b1;
                    source_id_next = '0;
                    if (cls_reg.action == ACT_RECORD)
                    begin
                        status_next = hit ? ST_AMBIGUOUS : ST_RECORDED;
                        upd_we      = cls_reg.in_range & ~hit;
                    end
                    else if (hit)
                    begin
                        status_next    = ST_RESOLVED;
                        source_id_next = ram_rdata[ID_W-1:0];
                    end
                    else
                    begin
                        status_next = cls_reg.zero_value ? ST_INITIAL : ST_NO_STORE;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        ram_we    = clearing_reg | upd_we;
        ram_waddr = clearing_reg ? clr_idx_reg : key_reg;
        ram_wdata = clearing_reg ? '0 : {1'b1, id_reg};

        clearing  = clearing_reg;
        out_valid = out_valid_reg;
        status    = status_reg;
        source_id = source_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clearing_reg  <= clearing_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cls_reg <= q_cls;
            key_reg <= q_key;
            id_reg  <= q_id;
        end
        status_reg    <= status_next;
        source_id_reg <= source_id_next;
    end

endmodule
